// ===== hdl/blm_pkg.sv =====
package blm_pkg;

  localparam int unsigned TEMPO_STEPS = 19;
  localparam logic [4:0] TEMPO_IDX_MAX = 5'(TEMPO_STEPS - 1);
  localparam logic [4:0] TEMPO_IDX_RESET = 5'd5;
  localparam logic [9:0] COUNT_SAT = 10'd1023;
  localparam int unsigned MASK_W = 5;

  localparam logic [9:0] LOCKOUT_RESET = 10'd200;
  localparam logic [7:0] TONE_RESET = 8'd50;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_LOCKOUT = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TONE = 3'd4;

  typedef struct packed {
    logic [9:0] lockout_ms;
    logic [7:0] tone_ms;
  } blm_cfg_t;

  typedef struct packed {
    logic [MASK_W-1:0] led_mask;
    logic              tone_on;
    logic              accent;
    logic              running;
    logic [7:0]        tempo_bpm;
  } blm_result_t;

  // Beat interval in ms, 60000/BPM, for BPM = 70 + 10*idx
  function automatic logic [9:0] beat_interval(input logic [4:0] idx);
    logic [9:0] ms;
    case (idx)
      5'd0:    ms = 10'd857;
      5'd1:    ms = 10'd750;
      5'd2:    ms = 10'd666;
      5'd3:    ms = 10'd600;
      5'd4:    ms = 10'd545;
      5'd5:    ms = 10'd500;
      5'd6:    ms = 10'd461;
      5'd7:    ms = 10'd428;
      5'd8:    ms = 10'd400;
      5'd9:    ms = 10'd375;
      5'd10:   ms = 10'd352;
      5'd11:   ms = 10'd333;
      5'd12:   ms = 10'd315;
      5'd13:   ms = 10'd300;
      5'd14:   ms = 10'd285;
      5'd15:   ms = 10'd272;
      5'd16:   ms = 10'd260;
      5'd17:   ms = 10'd250;
      default: ms = 10'd240;
    endcase
    return ms;
  endfunction

  function automatic logic [7:0] tempo_to_bpm(input logic [4:0] idx);
    return 8'd70 + 8'(idx) * 8'd10;
  endfunction

endpackage

// ===== hdl/blm_cfg.sv =====
module blm_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [blm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output blm_pkg::blm_cfg_t              cfg
);
  import blm_pkg::*;

  logic [9:0] lockout_r;
  logic [7:0] tone_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lockout_r <= LOCKOUT_RESET;
      tone_r    <= TONE_RESET;
    end else if (wr_en) begin
      case (paddr)
        REG_LOCKOUT: lockout_r <= pwdata[9:0];
        REG_TONE:    tone_r    <= pwdata[7:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      REG_LOCKOUT: prdata = 32'(lockout_r);
      REG_TONE:    prdata = 32'(tone_r);
      default:     prdata = '0;
    endcase
  end

  assign cfg.lockout_ms = lockout_r;
  assign cfg.tone_ms    = tone_r;

endmodule

// ===== hdl/blm_core.sv =====
module blm_core #(
  parameter int unsigned LED_COUNT = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic                  start_level,
  input  logic                  faster_level,
  input  logic                  slower_level,
  input  blm_pkg::blm_cfg_t     cfg,
  output blm_pkg::blm_result_t  res
);
  import blm_pkg::*;

  localparam int unsigned PW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [PW-1:0] LAST = PW'(LED_COUNT - 1);

  logic          run_r, run_nxt;
  logic          prev_s_r, prev_f_r, prev_d_r;
  logic [9:0]    since_press_r, since_press_nxt;
  logic [9:0]    since_beat_r, since_beat_nxt;
  logic [PW-1:0] beat_pos_r, beat_pos_nxt;
  logic          down_r, down_nxt;
  logic [4:0]    tempo_r, tempo_nxt;
  logic [7:0]    tone_left_r, tone_left_nxt;
  logic [PW-1:0] lit_pos_r, lit_pos_nxt;
  logic          lit_acc_r, lit_acc_nxt;

  logic [9:0]    sp_inc, sb_inc;
  logic          start_hit, stop_hit, beat;
  logic [4:0]    tempo_f;
  logic [7:0]    tone_cur;

  always_comb begin
    sp_inc = (since_press_r == COUNT_SAT) ? COUNT_SAT : since_press_r + 10'd1;
    sb_inc = (since_beat_r == COUNT_SAT) ? COUNT_SAT : since_beat_r + 10'd1;

    start_hit = !start_level && prev_s_r && (sp_inc > cfg.lockout_ms);
    run_nxt   = run_r ^ start_hit;
    stop_hit  = start_hit && run_r;
    since_press_nxt = start_hit ? 10'd0 : sp_inc;

    // faster first, then slower, each clamped at its end
    tempo_f   = (!faster_level && prev_f_r && tempo_r < TEMPO_IDX_MAX) ? tempo_r + 5'd1 : tempo_r;
    tempo_nxt = (!slower_level && prev_d_r && tempo_f != 5'd0) ? tempo_f - 5'd1 : tempo_f;

    beat = run_nxt && (sb_inc >= beat_interval(tempo_nxt));

    since_beat_nxt = beat ? 10'd0 : sb_inc;
    lit_pos_nxt    = lit_pos_r;
    lit_acc_nxt    = lit_acc_r;
    beat_pos_nxt   = beat_pos_r;
    down_nxt       = down_r;
    tone_cur       = stop_hit ? 8'd0 : tone_left_r;

    if (beat) begin
      lit_pos_nxt = beat_pos_r;
      lit_acc_nxt = (beat_pos_r == '0) || (beat_pos_r == LAST);
      tone_cur    = cfg.tone_ms;
      // bounce between the end LEDs
      if (!down_r) begin
        if ({1'b0, beat_pos_r} + (PW+1)'(1) >= {1'b0, LAST}) begin
          beat_pos_nxt = LAST;
          down_nxt     = 1'b1;
        end else begin
          beat_pos_nxt = beat_pos_r + PW'(1);
        end
      end else begin
        if (beat_pos_r <= PW'(1)) begin
          beat_pos_nxt = '0;
          down_nxt     = 1'b0;
        end else begin
          beat_pos_nxt = beat_pos_r - PW'(1);
        end
      end
    end

    res.running   = run_nxt;
    res.tempo_bpm = tempo_to_bpm(tempo_nxt);
    if (tone_cur != 8'd0) begin
      res.led_mask  = (32'(lit_pos_nxt) < MASK_W) ? (MASK_W'(1) << lit_pos_nxt) : '0;
      res.tone_on   = 1'b1;
      res.accent    = lit_acc_nxt;
      tone_left_nxt = tone_cur - 8'd1;
    end else begin
      res.led_mask  = '0;
      res.tone_on   = 1'b0;
      res.accent    = 1'b0;
      tone_left_nxt = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r         <= 1'b0;
      prev_s_r      <= 1'b1;
      prev_f_r      <= 1'b1;
      prev_d_r      <= 1'b1;
      since_press_r <= '0;
      since_beat_r  <= '0;
      beat_pos_r    <= '0;
      down_r        <= 1'b0;
      tempo_r       <= TEMPO_IDX_RESET;
      tone_left_r   <= '0;
      lit_pos_r     <= '0;
      lit_acc_r     <= 1'b0;
    end else if (step) begin
      run_r         <= run_nxt;
      prev_s_r      <= start_level;
      prev_f_r      <= faster_level;
      prev_d_r      <= slower_level;
      since_press_r <= since_press_nxt;
      since_beat_r  <= since_beat_nxt;
      beat_pos_r    <= beat_pos_nxt;
      down_r        <= down_nxt;
      tempo_r       <= tempo_nxt;
      tone_left_r   <= tone_left_nxt;
      lit_pos_r     <= lit_pos_nxt;
      lit_acc_r     <= lit_acc_nxt;
    end
  end

`ifndef SYNTHESIS
  a_tone_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    tone_left_r != 8'd0 |-> run_r)
    else $error("tone pending while stopped");

  a_tempo_range: assert property (@(posedge clk) disable iff (!rst_n)
    tempo_r <= TEMPO_IDX_MAX)
    else $error("tempo index out of range");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    beat_pos_r <= LAST)
    else $error("beat position past last LED");

  a_beat_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && beat |=> since_beat_r == 10'd0)
    else $error("beat did not restart interval count");
`endif

endmodule

// ===== hdl/blm_outbuf.sv =====
module blm_outbuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  blm_pkg::blm_result_t din,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output blm_pkg::blm_result_t dout
);
  import blm_pkg::*;

  logic        out_valid_r, skid_valid_r;
  blm_result_t out_r, skid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && !out_stall) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= load;
      end
    end else if (!out_valid_r) begin
      out_valid_r <= load;
    end else if (load) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && !out_stall) begin
      out_r <= skid_valid_r ? skid_r : din;
    end else if (!out_valid_r) begin
      out_r <= din;
    end else if (load) begin
      skid_r <= din;
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign dout      = out_r;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a beat ahead of output");

  a_no_load_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !load)
    else $error("load into full buffer");

  a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r)
    else $error("stalled beat dropped");
`endif

endmodule

// ===== hdl/bouncing_led_metronome_unit.sv =====
// Bouncing LED metronome. Each input beat is one millisecond tick with the
// three active-low button levels; every accepted tick yields exactly one
// result beat with the LED drive, tone enable, accent and current run flag
// and tempo. The state update is a single registered pass, so a tick can be
// taken every clock cycle while in_stall is low; its result is registered in
// the two-entry output buffer, which absorbs output stalls. in_stall rises
// only once two results are waiting. The user must set lockout_ms (address 0)
// and tone_ms (address 4) via APB while no ticks are in flight (not enforced).
module bouncing_led_metronome_unit #(
  parameter int unsigned LED_COUNT = 5
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_start_level,
  input  logic                                   in_faster_level,
  input  logic                                   in_slower_level,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [blm_pkg::MASK_W-1:0]             out_led_mask,
  output logic                                   out_tone_on,
  output logic                                   out_accent,
  output logic                                   out_running,
  output logic [7:0]                             out_tempo_bpm,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [blm_pkg::CFG_ADDR_W-1:0]         paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  import blm_pkg::*;

  blm_cfg_t    cfg;
  blm_result_t res, res_out;
  logic        full, accept;

  assign in_stall = full;
  assign accept   = in_valid & ~full;

  blm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  blm_core #(
    .LED_COUNT (LED_COUNT)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (accept),
    .start_level  (in_start_level),
    .faster_level (in_faster_level),
    .slower_level (in_slower_level),
    .cfg          (cfg),
    .res          (res)
  );

  blm_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .din       (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dout      (res_out)
  );

  assign out_led_mask  = res_out.led_mask;
  assign out_tone_on   = res_out.tone_on;
  assign out_accent    = res_out.accent;
  assign out_running   = res_out.running;
  assign out_tempo_bpm = res_out.tempo_bpm;

endmodule
